// ===== hdl/sliding_median_filter_3axis_defines.svh =====
// Assertion macros shared by the filter RTL.
// Each check is sampled at the rising edge of i_clk and is skipped while i_rst_n is low.
// SMF3_ASSERT holds a property at every edge.
// SMF3_ASSERT_IMP holds an implication from an antecedent to a consequent.
`ifndef SLIDING_MEDIAN_FILTER_3AXIS_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_3AXIS_DEFINES_SVH

`ifndef SYNTHESIS
`define SMF3_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("filter assertion failed");
`define SMF3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("filter implication failed");
`else
`define SMF3_ASSERT(lbl, prop)
`define SMF3_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== hdl/smf3_pkg.sv =====
package smf3_pkg;

    // Port width of every sample and median field
    localparam int FIELD_BITS = 32;

    // Default window length and compare width
    localparam int DEF_WINDOW      = 3;
    localparam int DEF_SAMPLE_BITS = 32;

endpackage

// ===== hdl/smf3_lane.sv =====
module smf3_lane #(
    parameter int WINDOW      = 3,
    parameter int SAMPLE_BITS = 32,
    parameter int SLOT_W      = 2,
    parameter int CNT_W       = 2
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [SLOT_W-1:0]      i_wr_slot,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [CNT_W-1:0]       i_count,
    output logic [SAMPLE_BITS-1:0] o_median
);

    logic [SAMPLE_BITS-1:0] r_hist [WINDOW];
    logic [WINDOW-1:0]      hit;
    logic [CNT_W-1:0]       target;

    // Write the new sample over the oldest slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_hist[i_wr_slot] <= i_sample;
        end
    end

    // Rank every held entry against the others; ties go by slot order
    always_comb begin
        logic [WINDOW-1:0] less;
        logic [CNT_W-1:0]  rank;
        target   = i_count >> 1;
        hit      = '0;
        o_median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            less = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if ((CNT_W'(j) < i_count) &&
                    (($signed(r_hist[j]) < $signed(r_hist[i])) ||
                     ((r_hist[j] == r_hist[i]) && (j < i)))) begin
                    less[j] = 1'b1;
                end
            end
            rank   = CNT_W'($countones(less));
            hit[i] = (CNT_W'(i) < i_count) && (rank == target);
        end
        // Pick the entry whose rank hits the middle
        for (int i = 0; i < WINDOW; i++) begin
            if (hit[i]) begin
                o_median = o_median | r_hist[i];
            end
        end
    end

endmodule

// ===== hdl/smf3_merge.sv =====
module smf3_merge #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load_vld,
    input  logic [SAMPLE_BITS-1:0]            i_x_med,
    input  logic [SAMPLE_BITS-1:0]            i_y_med,
    input  logic [SAMPLE_BITS-1:0]            i_z_med,
    output logic                              o_busy,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [smf3_pkg::FIELD_BITS-1:0] o_x_median,
    output logic signed [smf3_pkg::FIELD_BITS-1:0] o_y_median,
    output logic signed [smf3_pkg::FIELD_BITS-1:0] o_z_median
);

    import smf3_pkg::*;

    logic                   r_vld;
    logic                   n_vld;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [SAMPLE_BITS-1:0] r_y;
    logic [SAMPLE_BITS-1:0] r_z;

    // Output word is held while the sink stalls
    assign o_busy = r_vld && i_stall;
    assign n_vld  = o_busy ? 1'b1 : i_load_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Capture the three lane medians as one word
    always_ff @(posedge i_clk) begin
        if (!o_busy && i_load_vld) begin
            r_x <= i_x_med;
            r_y <= i_y_med;
            r_z <= i_z_med;
        end
    end

    assign o_valid    = r_vld;
    assign o_x_median = FIELD_BITS'(r_x);
    assign o_y_median = FIELD_BITS'(r_y);
    assign o_z_median = FIELD_BITS'(r_z);

endmodule

// ===== hdl/sliding_median_filter_3axis.sv =====
// Three-axis running median over the last WINDOW points. Each accepted word
// writes x, y and z into their own history windows, and the median of every
// axis is then registered as one word in the merge stage; while the window is
// still filling with k points the result is the element at sorted index k/2.
// The block takes one word per clock unless it stalls: the history write and
// the output register form a two-stage pipeline, and the per-axis rank compare
// of the WINDOW entries is combinational between them. Samples are compared as
// signed SAMPLE_BITS-wide values taken from the low bits of each field; medians
// are returned zero-extended or truncated to the 32-bit ports.
`include "sliding_median_filter_3axis_defines.svh"

module sliding_median_filter_3axis #(
    parameter int WINDOW      = smf3_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = smf3_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [smf3_pkg::FIELD_BITS-1:0] i_x_sample,
    input  logic signed [smf3_pkg::FIELD_BITS-1:0] i_y_sample,
    input  logic signed [smf3_pkg::FIELD_BITS-1:0] i_z_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [smf3_pkg::FIELD_BITS-1:0] o_x_median,
    output logic signed [smf3_pkg::FIELD_BITS-1:0] o_y_median,
    output logic signed [smf3_pkg::FIELD_BITS-1:0] o_z_median
);

    import smf3_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    logic                   in_acc;
    logic                   busy;
    logic                   r_s1_vld;
    logic                   n_s1_vld;
    logic [CNT_W-1:0]       r_fill;
    logic [CNT_W-1:0]       n_fill;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      n_slot;
    logic [SAMPLE_BITS-1:0] x_med;
    logic [SAMPLE_BITS-1:0] y_med;
    logic [SAMPLE_BITS-1:0] z_med;

    // Hold the input while the window word cannot move on
    assign o_stall = r_s1_vld && busy;
    assign in_acc  = i_valid && !o_stall;

    // Advance fill count (saturating at WINDOW) and oldest slot on each accepted word
    always_comb begin
        n_s1_vld = in_acc ? 1'b1 : (busy ? r_s1_vld : 1'b0);
        n_fill   = r_fill;
        n_slot   = r_slot;
        if (in_acc) begin
            if (r_fill != CNT_W'(WINDOW)) begin
                n_fill = r_fill + 1'b1;
            end
            n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fill   <= '0;
            r_slot   <= '0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_fill   <= n_fill;
            r_slot   <= n_slot;
        end
    end

    // One median lane per axis
    smf3_lane #(
        .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .SLOT_W(SLOT_W), .CNT_W(CNT_W)
    ) u_lane_x (
        .i_clk(i_clk), .i_wr_en(in_acc), .i_wr_slot(r_slot),
        .i_sample(SAMPLE_BITS'($unsigned(i_x_sample))), .i_count(r_fill),
        .o_median(x_med)
    );

    smf3_lane #(
        .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .SLOT_W(SLOT_W), .CNT_W(CNT_W)
    ) u_lane_y (
        .i_clk(i_clk), .i_wr_en(in_acc), .i_wr_slot(r_slot),
        .i_sample(SAMPLE_BITS'($unsigned(i_y_sample))), .i_count(r_fill),
        .o_median(y_med)
    );

    smf3_lane #(
        .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .SLOT_W(SLOT_W), .CNT_W(CNT_W)
    ) u_lane_z (
        .i_clk(i_clk), .i_wr_en(in_acc), .i_wr_slot(r_slot),
        .i_sample(SAMPLE_BITS'($unsigned(i_z_sample))), .i_count(r_fill),
        .o_median(z_med)
    );

    // Merge the lane results into the output word
    smf3_merge #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load_vld(r_s1_vld),
        .i_x_med(x_med), .i_y_med(y_med), .i_z_med(z_med),
        .o_busy(busy), .o_valid(o_valid), .i_stall(i_stall),
        .o_x_median(o_x_median), .o_y_median(o_y_median), .o_z_median(o_z_median)
    );

    `SMF3_ASSERT(a_fill_range, r_fill <= CNT_W'(WINDOW))
    `SMF3_ASSERT(a_slot_range, r_slot <= SLOT_W'(WINDOW - 1))
    `SMF3_ASSERT_IMP(a_fill_step, in_acc && (r_fill != CNT_W'(WINDOW)), r_fill == $past(r_fill) + 1'b1)
    `SMF3_ASSERT_IMP(a_hold_window, r_s1_vld && busy, $stable(r_fill) && $stable(r_slot) && r_s1_vld)

endmodule
